>>> rtl/scaled_alpha_layer_compositor_unit_macros.svh
// ----------------------------------------------------------------------------
// Scaled alpha layer compositor: assertion macros
// Concurrent checks on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALED_ALPHA_LAYER_COMPOSITOR_UNIT_MACROS_SVH
`define SCALED_ALPHA_LAYER_COMPOSITOR_UNIT_MACROS_SVH

// same-cycle implication
`define SALC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("salc check failed");

// next-cycle implication
`define SALC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("salc check failed");

`endif

>>> rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// Scaled alpha layer compositor: package
// Word types, command and status structs, codes and color helpers.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int SRC_SIZE_DEF = 60;
    localparam int MAX_DIM_DEF  = 128;
    localparam int SRC_X_W      = 6;
    localparam int MAX_RUN      = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 8'd128;
    localparam logic [CFG_IDX_W-1:0]  CFG_OUT_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_OUT_HEIGHT = 1'b1;
    localparam logic [7:0]            ALPHA_OPAQUE   = 8'hFF;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LAYER = 2'd1,
        REQ_PIXEL = 2'd2,
        REQ_READ  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        NUM_ROW,
        NUM_LO,
        NUM_HI
    } t_num_sel;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ROW_MUL,
        ST_ROW_SET,
        ST_CHECK,
        ST_LO_MUL,
        ST_HI_NUM,
        ST_HI_MUL,
        ST_SPAN,
        ST_SPAN_CHK,
        ST_COL_RD,
        ST_COL_BL,
        ST_COL_WR,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        t_req_type  req_type;
        logic [5:0] src_x;
        logic [5:0] src_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [6:0] read_x;
        logic [6:0] read_y;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  pix_x;
        logic [6:0]  pix_y;
        logic [15:0] pixel_color;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic     cap;
        logic     clr_step;
        logic     layer_reset;
        t_num_sel num_sel;
        logic     num_load;
        logic     prod_load;
        logic     row_update;
        logic     lo_load;
        logic     span_load;
        logic     col_rd;
        logic     col_blend;
        logic     col_wr;
        logic     rd_issue;
        logic     rd_emit;
    } t_dp_cmd;

    typedef struct packed {
        t_req_type req_type;
        logic      sx_zero;
        logic      alpha_zero;
        logic      row_active;
        logic      span_empty;
        logic      col_last;
        logic      clr_last;
    } t_dp_sts;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [15:0] blend565(input logic [15:0] dst, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b,
                                             input logic [7:0] a);
        logic [7:0]  dr, dg, db, ia;
        logic [15:0] sr, sg, sb;
        dr = {dst[15:11], 3'b000};
        dg = {dst[10:5], 2'b00};
        db = {dst[4:0], 3'b000};
        ia = ALPHA_OPAQUE - a;
        sr = {8'd0, r} * {8'd0, a} + {8'd0, dr} * {8'd0, ia};
        sg = {8'd0, g} * {8'd0, a} + {8'd0, dg} * {8'd0, ia};
        sb = {8'd0, b} * {8'd0, a} + {8'd0, db} * {8'd0, ia};
        return {sr[15:11], sg[15:10], sb[15:11]};
    endfunction

endpackage

>>> rtl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// Scaled alpha layer compositor: controller
// Sequences clear, row mapping, column span and read-modify-write steps.
// ----------------------------------------------------------------------------
module salc_ctrl import salc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.num_sel = NUM_ROW;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.cap = i_start;
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.req_type)
                    REQ_CLEAR: n_state = ST_CLEAR;
                    REQ_LAYER: begin
                        o_cmd.layer_reset = 1'b1;
                        n_state = ST_IDLE;
                    end
                    REQ_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state = ST_RD_OUT;
                    end
                    REQ_PIXEL: begin
                        if (i_sts.sx_zero) begin
                            o_cmd.num_load = 1'b1;
                            o_cmd.num_sel  = NUM_ROW;
                            n_state = ST_ROW_MUL;
                        end else begin
                            n_state = ST_CHECK;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_ROW_MUL: begin
                o_cmd.prod_load = 1'b1;
                n_state = ST_ROW_SET;
            end
            ST_ROW_SET: begin
                o_cmd.row_update = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_sts.row_active || i_sts.alpha_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.num_load = 1'b1;
                    o_cmd.num_sel  = NUM_LO;
                    n_state = ST_LO_MUL;
                end
            end
            ST_LO_MUL: begin
                o_cmd.prod_load = 1'b1;
                n_state = ST_HI_NUM;
            end
            ST_HI_NUM: begin
                o_cmd.lo_load  = 1'b1;
                o_cmd.num_load = 1'b1;
                o_cmd.num_sel  = NUM_HI;
                n_state = ST_HI_MUL;
            end
            ST_HI_MUL: begin
                o_cmd.prod_load = 1'b1;
                n_state = ST_SPAN;
            end
            ST_SPAN: begin
                o_cmd.span_load = 1'b1;
                n_state = ST_SPAN_CHK;
            end
            ST_SPAN_CHK: begin
                n_state = i_sts.span_empty ? ST_IDLE : ST_COL_RD;
            end
            ST_COL_RD: begin
                o_cmd.col_rd = 1'b1;
                n_state = ST_COL_BL;
            end
            ST_COL_BL: begin
                o_cmd.col_blend = 1'b1;
                n_state = ST_COL_WR;
            end
            ST_COL_WR: begin
                o_cmd.col_wr = 1'b1;
                n_state = i_sts.col_last ? ST_IDLE : ST_COL_RD;
            end
            ST_RD_OUT: begin
                o_cmd.rd_emit = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> rtl/salc_datapath.sv
// ----------------------------------------------------------------------------
// Scaled alpha layer compositor: datapath
// Frame store, config registers, reciprocal divider, row state and blend.
// ----------------------------------------------------------------------------
module salc_datapath import salc_pkg::*; #(
    parameter int SRC_SIZE = SRC_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_strobe,
    output t_out_word             o_out
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int ROW_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int NUM_MAX = (1 << SRC_X_W) * MAX_DIM + SRC_SIZE - 1;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int SH      = $clog2(NUM_MAX * SRC_SIZE) + 1;
    localparam longint RECIP = ((longint'(1) << SH) + SRC_SIZE - 1) / SRC_SIZE;
    localparam int PROD_W  = NUM_W + SH + 1;

    logic [15:0] mem [DEPTH];

    logic [CFG_DATA_W-1:0] r_width, r_height;
    t_in_word              r_in;
    logic [NUM_W-1:0]      r_num, n_num;
    logic [PROD_W-1:0]     r_prod;
    logic [NUM_W-1:0]      r_c_lo;
    logic [ROW_W-1:0]      r_last_row;
    logic                  r_last_valid, r_row_active;
    logic [ROW_W-1:0]      r_c;
    logic [DIM_W-1:0]      r_c_end;
    logic                  r_span_empty;
    logic [AW-1:0]         r_clr_cnt;
    logic [15:0]           r_rdata, r_color;
    logic                  r_strobe;
    t_out_word             r_out;

    logic [DIM_W-1:0]  w_dim, h_dim;
    logic [6:0]        mul_a;
    logic [DIM_W-1:0]  mul_b;
    logic [NUM_W-1:0]  mul_add;
    logic [NUM_W-1:0]  quot;
    logic              row_skip;
    logic [NUM_W:0]    end_v, lo3, hi_e, w_e;
    logic [AW-1:0]     col_addr, rd_addr, raddr;
    logic              rd_in_range, col_last, clr_last;

    always_comb begin
        w_dim = (r_width == '0) ? DIM_W'(1)
              : ((int'(r_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_width));
        h_dim = (r_height == '0) ? DIM_W'(1)
              : ((int'(r_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_DIM_RESET;
            r_height <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OUT_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_OUT_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_in <= i_in;
        end
    end

    // numerator for the divide by the source size
    always_comb begin
        mul_a   = {1'b0, r_in.src_y};
        mul_b   = h_dim;
        mul_add = '0;
        unique case (i_cmd.num_sel)
            NUM_ROW: begin
                mul_a   = {1'b0, r_in.src_y};
                mul_b   = h_dim;
                mul_add = '0;
            end
            NUM_LO: begin
                mul_a   = {1'b0, r_in.src_x};
                mul_b   = w_dim;
                mul_add = NUM_W'(SRC_SIZE - 1);
            end
            NUM_HI: begin
                mul_a   = {1'b0, r_in.src_x} + 7'd1;
                mul_b   = w_dim;
                mul_add = NUM_W'(SRC_SIZE - 1);
            end
            default: ;
        endcase
        n_num = NUM_W'(mul_a * mul_b + mul_add);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.num_load) begin
            r_num <= n_num;
        end
        if (i_cmd.prod_load) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
        end
        if (i_cmd.lo_load) begin
            r_c_lo <= quot;
        end
    end

    assign quot = r_prod[SH +: NUM_W];

    assign row_skip = (quot >= NUM_W'(h_dim))
                   || (r_last_valid && (quot == NUM_W'(r_last_row)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
            r_row_active <= 1'b0;
        end else if (i_cmd.layer_reset) begin
            r_last_valid <= 1'b0;
            r_row_active <= 1'b0;
        end else if (i_cmd.row_update) begin
            if (row_skip) begin
                r_row_active <= 1'b0;
            end else begin
                r_last_valid <= 1'b1;
                r_row_active <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_update && !row_skip) begin
            r_last_row <= ROW_W'(quot);
        end
    end

    // covered columns: ceil(sx*w/S) up to ceil((sx+1)*w/S), capped by w and run
    always_comb begin
        lo3   = (NUM_W + 1)'(r_c_lo) + (NUM_W + 1)'(MAX_RUN);
        hi_e  = (NUM_W + 1)'(quot);
        w_e   = (NUM_W + 1)'(w_dim);
        end_v = hi_e;
        if (w_e < end_v) begin
            end_v = w_e;
        end
        if (lo3 < end_v) begin
            end_v = lo3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.span_load) begin
            r_c          <= ROW_W'(r_c_lo);
            r_c_end      <= DIM_W'(end_v);
            r_span_empty <= ((NUM_W + 1)'(r_c_lo) >= end_v);
        end else if (i_cmd.col_wr) begin
            r_c <= r_c + ROW_W'(1);
        end
    end

    assign col_addr    = AW'(int'(r_last_row) * MAX_DIM + int'(r_c));
    assign col_last    = ((DIM_W'(r_c) + DIM_W'(1)) == r_c_end);
    assign rd_in_range = (int'(r_in.read_x) < MAX_DIM) && (int'(r_in.read_y) < MAX_DIM);
    assign rd_addr     = rd_in_range ? AW'(int'(r_in.read_y) * MAX_DIM + int'(r_in.read_x))
                                     : '0;
    assign raddr       = i_cmd.rd_issue ? rd_addr : col_addr;
    assign clr_last    = (r_clr_cnt == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= clr_last ? '0 : r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_cnt] <= '0;
        end else if (i_cmd.col_wr) begin
            mem[col_addr] <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_rd || i_cmd.rd_issue) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_blend) begin
            r_color <= (r_in.alpha == ALPHA_OPAQUE)
                     ? pack565(r_in.red, r_in.green, r_in.blue)
                     : blend565(r_rdata, r_in.red, r_in.green, r_in.blue, r_in.alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.col_wr || i_cmd.rd_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_wr) begin
            r_out.pix_x       <= 7'(r_c);
            r_out.pix_y       <= 7'(r_last_row);
            r_out.pixel_color <= r_color;
            r_out.last_of_run <= col_last;
        end else if (i_cmd.rd_emit) begin
            r_out.pix_x       <= r_in.read_x;
            r_out.pix_y       <= r_in.read_y;
            r_out.pixel_color <= rd_in_range ? r_rdata : 16'd0;
            r_out.last_of_run <= 1'b1;
        end
    end

    always_comb begin
        o_sts.req_type   = r_in.req_type;
        o_sts.sx_zero    = (r_in.src_x == '0);
        o_sts.alpha_zero = (r_in.alpha == '0);
        o_sts.row_active = r_row_active;
        o_sts.span_empty = r_span_empty;
        o_sts.col_last   = col_last;
        o_sts.clr_last   = clr_last;
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

>>> rtl/scaled_alpha_layer_compositor_unit.sv
// ----------------------------------------------------------------------------
// Scaled alpha layer compositor unit
// Scales RGBA source rows into an RGB565 frame store with alpha blending.
//
//   channel   signals                            handshake
//   request   start, busy, i_in                  start high while busy low
//   result    o_strobe, o_out                    one-cycle strobe, no back-pressure
//   config    i_cfg_we, i_cfg_idx, i_cfg_wdata   write on i_cfg_we, no wait
//
// Source pixel: decode, then at a row start a row multiply and row update, then the
// row check, which drops the pixel or goes on to span setup through the shared
// reciprocal multiplier, then read, blend and write per covered column, then idle.
// Read: decode, then output. Start layer: decode. Clear: one write per store word.
// After reset the same clearing pass runs with busy high.
// Results cannot be stalled; each word is shown for one cycle.
// ----------------------------------------------------------------------------
`include "scaled_alpha_layer_compositor_unit_macros.svh"

module scaled_alpha_layer_compositor_unit import salc_pkg::*; #(
    parameter int SRC_SIZE = SRC_SIZE_DEF,
    parameter int MAX_DIM  = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_in,
    output logic                  o_strobe,
    output t_out_word             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    salc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    salc_datapath #(
        .SRC_SIZE (SRC_SIZE),
        .MAX_DIM  (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

    `SALC_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `SALC_ASSERT_IMP(a_run_busy, o_strobe && !o_out.last_of_run, busy)
    `SALC_ASSERT_NXT(a_strobe_gap, o_strobe, !o_strobe)

endmodule

>>> tb/compositor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compositor checker
// Watches the request, result and register channels of the compositor,
// predicts every result word from its own copy of the frame store, row state
// and dimensions, and compares each emitted word against the oldest prediction.
// ----------------------------------------------------------------------------
module compositor_checker import salc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in_word              i_in,
    input  logic                  i_strobe,
    input  t_out_word             i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int SRC_DIM   = SRC_SIZE_DEF;
    localparam int STORE_DIM = MAX_DIM_DEF;

    logic [15:0] store_mem [0:STORE_DIM*STORE_DIM-1];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    int          drawn_row;
    logic        drawn_row_ok;
    logic        row_live;
    t_out_word   pending_pixels[$];
    int          fail_count;
    int          checked_count;
    int          clr_idx;

    function automatic int eff_dim(input logic [7:0] v);
        if (v == 8'd0) begin
            return 1;
        end
        if (int'(v) > STORE_DIM) begin
            return STORE_DIM;
        end
        return int'(v);
    endfunction

    function automatic logic [15:0] mix_color(input logic [15:0] dst, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b,
                                              input logic [7:0] a);
        int dr, dg, db, ia, nr, ng, nb;
        dr = int'(dst[15:11]) << 3;
        dg = int'(dst[10:5]) << 2;
        db = int'(dst[4:0]) << 3;
        ia = 255 - int'(a);
        nr = (int'(r) * int'(a) + dr * ia) >> 8;
        ng = (int'(g) * int'(a) + dg * ia) >> 8;
        nb = (int'(b) * int'(a) + db * ia) >> 8;
        return {nr[7:3], ng[7:2], nb[7:3]};
    endfunction

    task automatic composite_request(input t_in_word req);
        int        w_eff, h_eff, out_row, col, addr, made, k;
        logic [15:0] color;
        t_out_word word;
        t_out_word run_words[MAX_RUN];
        w_eff = eff_dim(width_reg);
        h_eff = eff_dim(height_reg);
        case (req.req_type)
            REQ_CLEAR: begin
                for (k = 0; k < STORE_DIM * STORE_DIM; k++) begin
                    store_mem[k] = 16'd0;
                end
            end
            REQ_LAYER: begin
                drawn_row_ok = 1'b0;
                row_live     = 1'b0;
            end
            REQ_READ: begin
                word.pix_x       = req.read_x;
                word.pix_y       = req.read_y;
                word.pixel_color = store_mem[{req.read_y, req.read_x}];
                word.last_of_run = 1'b1;
                pending_pixels.push_back(word);
            end
            REQ_PIXEL: begin
                if (req.src_x == 6'd0) begin
                    out_row = (int'(req.src_y) * h_eff) / SRC_DIM;
                    if (out_row >= h_eff || (drawn_row_ok && out_row == drawn_row)) begin
                        row_live = 1'b0;
                    end else begin
                        drawn_row    = out_row;
                        drawn_row_ok = 1'b1;
                        row_live     = 1'b1;
                    end
                end
                if (row_live && req.alpha != 8'd0) begin
                    made = 0;
                    for (col = 0; col < w_eff && made < MAX_RUN; col++) begin
                        if ((col * SRC_DIM) / w_eff == int'(req.src_x)) begin
                            addr = drawn_row * STORE_DIM + col;
                            if (req.alpha == ALPHA_OPAQUE) begin
                                color = {req.red[7:3], req.green[7:2], req.blue[7:3]};
                            end else begin
                                color = mix_color(store_mem[addr], req.red, req.green,
                                                  req.blue, req.alpha);
                            end
                            store_mem[addr] = color;
                            run_words[made].pix_x       = 7'(col);
                            run_words[made].pix_y       = 7'(drawn_row);
                            run_words[made].pixel_color = color;
                            run_words[made].last_of_run = 1'b0;
                            made++;
                        end
                    end
                    for (k = 0; k < made; k++) begin
                        if (k == made - 1) begin
                            run_words[k].last_of_run = 1'b1;
                        end
                        pending_pixels.push_back(run_words[k]);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (clr_idx = 0; clr_idx < STORE_DIM * STORE_DIM; clr_idx++) begin
                store_mem[clr_idx] = 16'd0;
            end
            width_reg     = CFG_DIM_RESET;
            height_reg    = CFG_DIM_RESET;
            drawn_row     = 0;
            drawn_row_ok  = 1'b0;
            row_live      = 1'b0;
            fail_count    = 0;
            checked_count = 0;
            pending_pixels.delete();
        end else begin
            if (i_strobe) begin
                checked_count++;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result word: pix_x %0d pix_y %0d color %h",
                           i_out.pix_x, i_out.pix_y, i_out.pixel_color);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (i_out.pix_x !== want.pix_x) begin
                        $error("pix_x: expected %0d, got %0d", want.pix_x, i_out.pix_x);
                        fail_count++;
                    end
                    if (i_out.pix_y !== want.pix_y) begin
                        $error("pix_y: expected %0d, got %0d", want.pix_y, i_out.pix_y);
                        fail_count++;
                    end
                    if (i_out.pixel_color !== want.pixel_color) begin
                        $error("pixel_color: expected %h, got %h",
                               want.pixel_color, i_out.pixel_color);
                        fail_count++;
                    end
                    if (i_out.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, i_out.last_of_run);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                composite_request(i_in);
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OUT_WIDTH) begin
                    width_reg = i_cfg_wdata;
                end else begin
                    height_reg = i_cfg_wdata;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_pixels.size();
        o_checked    <= checked_count;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compositor testbench
// Drives directed and random layer traffic (row starts, repeated and
// out-of-range rows, transparent, blended and opaque pixels, clears and
// read-backs) across several output dimensions, with random start gaps,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import salc_pkg::*;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_ITEMS  = 90;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_in;
    logic                  o_strobe;
    t_out_word             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int         fail_count;
    int         pending_words;
    int         checked_words;
    int         sent_count;
    int         item_count;
    int         setting_count;
    int         clears_left;
    int         cycle_count;
    int         phase;
    logic       burst_mode;
    logic [7:0] cur_w;
    logic [7:0] cur_h;

    scaled_alpha_layer_compositor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    compositor_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (i_in),
        .i_strobe    (o_strobe),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending_words),
        .o_checked   (checked_words)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_in_word random_word(input t_req_type kind);
        t_in_word w;
        w.req_type = kind;
        w.src_x    = 6'($urandom_range(0, 63));
        w.src_y    = 6'($urandom_range(0, 63));
        w.red      = 8'($urandom_range(0, 255));
        w.green    = 8'($urandom_range(0, 255));
        w.blue     = 8'($urandom_range(0, 255));
        w.alpha    = 8'($urandom_range(0, 255));
        w.read_x   = 7'($urandom_range(0, 127));
        w.read_y   = 7'($urandom_range(0, 127));
        return w;
    endfunction

    function automatic t_in_word pixel_word(input int sx, input int sy, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] a);
        t_in_word w;
        w       = random_word(REQ_PIXEL);
        w.src_x = 6'(sx);
        w.src_y = 6'(sy);
        w.red   = r;
        w.green = g;
        w.blue  = b;
        w.alpha = a;
        return w;
    endfunction

    function automatic t_in_word read_word(input int x, input int y);
        t_in_word w;
        w        = random_word(REQ_READ);
        w.read_x = 7'(x);
        w.read_y = 7'(y);
        return w;
    endfunction

    function automatic logic [7:0] pick_alpha();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return ALPHA_OPAQUE;
        end
        if (roll < 45) begin
            return 8'd0;
        end
        return 8'($urandom_range(1, 254));
    endfunction

    function automatic t_in_word any_pixel(input int sx, input int sy);
        return pixel_word(sx, sy, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), pick_alpha());
    endfunction

    // present a word and hold it until the block takes it
    task automatic send_word(input t_in_word w);
        start <= 1'b1;
        i_in  <= w;
        while (busy) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
        sent_count++;
        if (w.req_type == REQ_PIXEL || w.req_type == REQ_READ) begin
            item_count++;
        end
    endtask

    task automatic idle_gap();
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55) begin
            len = 0;
        end else if (roll < 92) begin
            len = $urandom_range(1, 3);
        end else begin
            len = $urandom_range(8, 40);
        end
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(negedge i_clk);
        end
    endtask

    // drain all expected words, then let any silent work finish
    task automatic settle();
        start <= 1'b0;
        while (pending_words != 0 || busy) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_dims(input logic [7:0] w, input logic [7:0] h);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_OUT_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_OUT_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_w = w;
        cur_h = h;
        setting_count++;
    endtask

    task automatic run_layer_pass();
        int       rows, extra, sx, sy, x_lim, y_lim;
        t_in_word w;
        send_word(random_word(REQ_LAYER));
        idle_gap();
        rows = $urandom_range(2, 4);
        repeat (rows) begin
            if ($urandom_range(0, 9) == 0) begin
                sy = $urandom_range(60, 63);
            end else begin
                sy = $urandom_range(0, 59);
            end
            send_word(any_pixel(0, sy));
            idle_gap();
            sx    = 0;
            extra = $urandom_range(1, 5);
            repeat (extra) begin
                sx = sx + $urandom_range(1, 12);
                if (sx > 63) begin
                    sx = $urandom_range(1, 63);
                end
                send_word(any_pixel(sx, $urandom_range(0, 63)));
                idle_gap();
            end
            if ($urandom_range(0, 9) < 2) begin
                w = random_word(t_req_type'($urandom_range(0, 3)));
                if (w.req_type == REQ_CLEAR) begin
                    if (clears_left > 0) begin
                        clears_left--;
                    end else begin
                        w.req_type = REQ_READ;
                    end
                end
                send_word(w);
                idle_gap();
            end
        end
        x_lim = (cur_w == 8'd0) ? 0 : ((cur_w > 8'd128) ? 127 : int'(cur_w) - 1);
        y_lim = (cur_h == 8'd0) ? 0 : ((cur_h > 8'd128) ? 127 : int'(cur_h) - 1);
        repeat (2) begin
            if ($urandom_range(0, 3) == 0) begin
                send_word(read_word($urandom_range(0, 127), $urandom_range(0, 127)));
            end else begin
                send_word(read_word($urandom_range(0, x_lim), $urandom_range(0, y_lim)));
            end
            idle_gap();
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped at the cycle limit");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        start         = 1'b0;
        i_in          = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_OUT_WIDTH;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        sent_count    = 0;
        item_count    = 0;
        setting_count = 0;
        clears_left   = 2;
        burst_mode    = 1'b0;
        cur_w         = CFG_DIM_RESET;
        cur_h         = CFG_DIM_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        send_word(random_word(REQ_LAYER));
        send_word(pixel_word(0, 0, 8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE));
        send_word(pixel_word(1, 0, 8'h00, 8'h00, 8'h00, 8'd128));
        send_word(pixel_word(59, 0, 8'hFF, 8'h00, 8'hFF, 8'd1));
        send_word(pixel_word(63, 5, 8'h80, 8'h80, 8'h80, ALPHA_OPAQUE));
        send_word(pixel_word(0, 0, 8'h11, 8'h22, 8'h33, ALPHA_OPAQUE));
        send_word(pixel_word(2, 0, 8'h44, 8'h55, 8'h66, ALPHA_OPAQUE));
        send_word(pixel_word(0, 1, 8'hFF, 8'hFF, 8'hFF, 8'd0));
        send_word(pixel_word(2, 9, 8'h12, 8'h34, 8'h56, ALPHA_OPAQUE));
        send_word(pixel_word(0, 63, 8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE));
        send_word(pixel_word(5, 63, 8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE));
        send_word(read_word(0, 0));
        send_word(read_word(127, 127));
        send_word(read_word(3, 0));
        send_word(random_word(REQ_CLEAR));
        send_word(read_word(0, 0));

        set_dims(8'd0, 8'd0);
        send_word(random_word(REQ_LAYER));
        send_word(pixel_word(0, 0, 8'hA5, 8'h5A, 8'hC3, 8'd200));
        send_word(pixel_word(1, 0, 8'hFF, 8'hFF, 8'hFF, ALPHA_OPAQUE));
        send_word(read_word(0, 0));

        set_dims(8'd255, 8'd255);
        send_word(random_word(REQ_LAYER));
        send_word(pixel_word(0, 59, 8'h7F, 8'hFE, 8'h01, 8'd254));
        send_word(read_word(2, 125));

        item_count = 0;
        phase      = 0;
        while (item_count < RANDOM_ITEMS) begin
            case (phase % 8)
                0: set_dims(8'd128, 8'd128);
                1: set_dims(8'd0, 8'd255);
                2: set_dims(8'd60, 8'd60);
                3: set_dims(8'd1, 8'd128);
                4: set_dims(8'd255, 8'd1);
                default: set_dims(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            run_layer_pass();
            phase++;
        end
        settle();

        $display("sent %0d requests under %0d dimension settings", sent_count, setting_count);
        $display("checked %0d result words", checked_words);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_datapath.sv
rtl/scaled_alpha_layer_compositor_unit.sv
tb/compositor_checker.sv
tb/testbench.sv
